/* hdl/ppc_pkg.sv */
// Package for the proximity pass counter: beat structs, phase and register codes,
// register reset values and the constants of the baseline divide.
// Used by every file in hdl; depends on nothing.
package ppc_pkg;

	localparam int DIST_W      = 14;
	localparam int MARGIN_W    = 8;
	localparam int QUIET_W     = 4;
	localparam int PCT_W       = 7;
	localparam int DUTY_W      = 10;
	localparam int HITS_W      = 16;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;

	localparam int CAL_SAMPLES = 5;
	localparam int CAL_CNT_W   = 3;
	localparam int CAL_SUM_W   = 17;
	localparam int CAL_SHIFT   = CAL_SUM_W + CAL_CNT_W;
	localparam int CAL_RECIP_W = CAL_SHIFT + 1;
	localparam int CAL_PROD_W  = CAL_SUM_W + CAL_RECIP_W;
	localparam logic [CAL_RECIP_W-1:0] CAL_RECIP =
		CAL_RECIP_W'(((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

	localparam logic [MARGIN_W-1:0] NEAR_MARGIN_RST   = 8'd4;
	localparam logic [MARGIN_W-1:0] DEEP_MARGIN_RST   = 8'd10;
	localparam logic [QUIET_W-1:0]  QUIET_SAMPLES_RST = 4'd5;
	localparam logic [PCT_W-1:0]    HIGH_SHARE_RST    = 7'd50;
	localparam logic [DUTY_W-1:0]   DUTY_NEAR_RST     = 10'd200;
	localparam logic [DUTY_W-1:0]   DUTY_MID_RST      = 10'd50;
	localparam logic [DUTY_W-1:0]   DUTY_DEEP_RST     = 10'd400;

	typedef enum logic [MODE_W-1:0] {
		PH_CAL   = 2'd0,
		PH_IDLE  = 2'd1,
		PH_TRACK = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR_MARGIN   = 3'd0,
		REG_DEEP_MARGIN   = 3'd1,
		REG_QUIET_SAMPLES = 3'd2,
		REG_HIGH_SHARE    = 3'd3,
		REG_DUTY_NEAR     = 3'd4,
		REG_DUTY_MID      = 3'd5,
		REG_DUTY_DEEP     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_mm;
		logic              recalibrate;
	} in_beat_t;

	typedef struct packed {
		logic              pass_detected;
		logic [DUTY_W-1:0] duty_level;
		logic [MODE_W-1:0] mode;
		logic [DIST_W-1:0] baseline_mm;
	} out_beat_t;

endpackage

/* hdl/proximity_pass_counter.sv */
// Proximity pass counter top level: input stage, baseline calibration, pass tracking
// and result register. Depends on ppc_pkg.
//
// channel | direction | handshake             | payload
// in      | in        | in_valid / in_stall   | in_data  (ppc_pkg::in_beat_t)
// out     | out       | out_valid / out_stall | out_data (ppc_pkg::out_beat_t)
// cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// One beat per cycle sustained while the result side does not stall; each sample passes
// through the input register and the update logic into the result register.
// Reset puts the block in calibration with registers at their default values.
// A stalled result holds; the input stage keeps accepting until it is full behind it.
module proximity_pass_counter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  ppc_pkg::in_beat_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output ppc_pkg::out_beat_t               out_data,
	input  logic                             cfg_we,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ppc_pkg::*;

	logic [MARGIN_W-1:0] near_margin_q, deep_margin_q;
	logic [QUIET_W-1:0]  quiet_samples_q;
	logic [PCT_W-1:0]    high_share_q;
	logic [DUTY_W-1:0]   duty_near_q, duty_mid_q, duty_deep_q;

	logic                 valid_s1;
	in_beat_t             beat_s1;
	logic                 out_valid_q;
	out_beat_t            out_q;
	logic                 advance;

	phase_t               phase_q, phase_nx;
	logic [CAL_SUM_W-1:0] cal_sum_q, cal_sum_nx, cal_sum_add;
	logic [CAL_CNT_W-1:0] cal_taken_q, cal_taken_nx, cal_taken_inc;
	logic [DIST_W-1:0]    baseline_q, baseline_nx;
	logic [HITS_W-1:0]    near_hits_q, near_hits_nx, near_inc;
	logic [HITS_W-1:0]    mid_hits_q, mid_hits_nx, mid_inc;
	logic [QUIET_W-1:0]   quiet_q, quiet_nx, quiet_dec;
	logic [DUTY_W-1:0]    duty_q, duty_nx;
	logic                 pass_nx;

	logic [DIST_W:0]         near_sum, deep_sum, base_ext;
	logic                    is_near, is_mid, is_deep;
	logic [CAL_PROD_W-1:0]   cal_prod;
	logic [HITS_W-1:0]       trk_near, trk_mid;
	logic [QUIET_W-1:0]      trk_quiet;
	logic signed [HITS_W+1:0] total;
	logic signed [HITS_W+9:0] share_prod;
	logic [HITS_W+7:0]       near_lim;
	logic                    pass_ok;

	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_margin_q   <= NEAR_MARGIN_RST;
			deep_margin_q   <= DEEP_MARGIN_RST;
			quiet_samples_q <= QUIET_SAMPLES_RST;
			high_share_q    <= HIGH_SHARE_RST;
			duty_near_q     <= DUTY_NEAR_RST;
			duty_mid_q      <= DUTY_MID_RST;
			duty_deep_q     <= DUTY_DEEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NEAR_MARGIN:   near_margin_q   <= cfg_data[MARGIN_W-1:0];
				REG_DEEP_MARGIN:   deep_margin_q   <= cfg_data[MARGIN_W-1:0];
				REG_QUIET_SAMPLES: quiet_samples_q <= cfg_data[QUIET_W-1:0];
				REG_HIGH_SHARE:    high_share_q    <= cfg_data[PCT_W-1:0];
				REG_DUTY_NEAR:     duty_near_q     <= cfg_data[DUTY_W-1:0];
				REG_DUTY_MID:      duty_mid_q      <= cfg_data[DUTY_W-1:0];
				REG_DUTY_DEEP:     duty_deep_q     <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_data;
		end
	end

	// level compares without signed subtraction
	always_comb begin
		base_ext = {1'b0, baseline_q};
		near_sum = {1'b0, beat_s1.distance_mm} + (DIST_W+1)'(near_margin_q);
		deep_sum = {1'b0, beat_s1.distance_mm} + (DIST_W+1)'(deep_margin_q);
		is_near  = near_sum <= base_ext;
		is_deep  = deep_sum < base_ext;
		is_mid   = beat_s1.distance_mm <= baseline_q;
	end

	always_comb begin
		cal_sum_add   = cal_sum_q + CAL_SUM_W'(beat_s1.distance_mm);
		cal_taken_inc = cal_taken_q + CAL_CNT_W'(1);
		cal_prod      = CAL_PROD_W'(cal_sum_add) * CAL_PROD_W'(CAL_RECIP);
		near_inc      = (near_hits_q == '1) ? near_hits_q : near_hits_q + HITS_W'(1);
		mid_inc       = (mid_hits_q == '1) ? mid_hits_q : mid_hits_q + HITS_W'(1);
		quiet_dec     = (quiet_q == '0) ? quiet_q : quiet_q - QUIET_W'(1);
	end

	// pass test: near >= floor(total * pct / 100) iff total * pct <= 100 * near + 99
	always_comb begin
		trk_near  = near_hits_q;
		trk_mid   = mid_hits_q;
		trk_quiet = quiet_q;
		if (is_near) begin
			trk_near  = near_inc;
			trk_quiet = quiet_samples_q;
		end else if (is_mid) begin
			trk_mid   = mid_inc;
			trk_quiet = quiet_dec;
		end
		total      = $signed({2'b00, trk_near}) + $signed({2'b00, trk_mid})
		           - $signed({(HITS_W+2-QUIET_W)'(0), quiet_samples_q});
		share_prod = total * $signed({1'b0, high_share_q});
		near_lim   = (HITS_W+8)'(trk_near) * (HITS_W+8)'(100) + (HITS_W+8)'(99);
		pass_ok    = share_prod <= $signed({2'b00, near_lim});
	end

	always_comb begin
		phase_nx     = phase_q;
		cal_sum_nx   = cal_sum_q;
		cal_taken_nx = cal_taken_q;
		baseline_nx  = baseline_q;
		near_hits_nx = near_hits_q;
		mid_hits_nx  = mid_hits_q;
		quiet_nx     = quiet_q;
		duty_nx      = duty_q;
		pass_nx      = 1'b0;
		unique case (phase_q)
			PH_CAL: begin
				if (cal_taken_inc >= CAL_CNT_W'(CAL_SAMPLES)) begin
					baseline_nx  = cal_prod[CAL_SHIFT +: DIST_W];
					cal_sum_nx   = '0;
					cal_taken_nx = '0;
					phase_nx     = PH_IDLE;
				end else begin
					cal_sum_nx   = cal_sum_add;
					cal_taken_nx = cal_taken_inc;
				end
			end
			PH_IDLE: begin
				if (is_near) begin
					near_hits_nx = '0;
					mid_hits_nx  = '0;
					quiet_nx     = quiet_samples_q;
					phase_nx     = PH_TRACK;
				end else if (beat_s1.recalibrate) begin
					cal_sum_nx   = '0;
					cal_taken_nx = '0;
					phase_nx     = PH_CAL;
				end
			end
			PH_TRACK: begin
				near_hits_nx = trk_near;
				mid_hits_nx  = trk_mid;
				quiet_nx     = trk_quiet;
				if (is_near) begin
					duty_nx = duty_near_q;
				end else if (is_mid) begin
					duty_nx = duty_mid_q;
				end
				if (is_deep) begin
					duty_nx = duty_deep_q;
				end
				if (trk_quiet == '0) begin
					if (pass_ok) begin
						pass_nx = 1'b1;
						duty_nx = '0;
					end
					near_hits_nx = '0;
					mid_hits_nx  = '0;
					phase_nx     = PH_IDLE;
				end
			end
			default: phase_nx = PH_CAL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CAL;
			cal_sum_q   <= '0;
			cal_taken_q <= '0;
			baseline_q  <= '0;
			near_hits_q <= '0;
			mid_hits_q  <= '0;
			quiet_q     <= '0;
			duty_q      <= '0;
		end else if (advance) begin
			phase_q     <= phase_nx;
			cal_sum_q   <= cal_sum_nx;
			cal_taken_q <= cal_taken_nx;
			baseline_q  <= baseline_nx;
			near_hits_q <= near_hits_nx;
			mid_hits_q  <= mid_hits_nx;
			quiet_q     <= quiet_nx;
			duty_q      <= duty_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.pass_detected <= pass_nx;
			out_q.duty_level    <= duty_nx;
			out_q.mode          <= phase_nx;
			out_q.baseline_mm   <= baseline_nx;
		end
	end

endmodule

/* hdl/ppc_checker.sv */
// Port-level checks for the proximity pass counter, bound to the top level.
// Depends on ppc_pkg and proximity_pass_counter.
module ppc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input ppc_pkg::in_beat_t                in_data,
	input logic                             out_valid,
	input logic                             out_stall,
	input ppc_pkg::out_beat_t               out_data,
	input logic                             cfg_we,
	input logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ppc_pkg::*;

	logic unused_ok;
	assign unused_ok = in_valid ^ (^in_data) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed under stall");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result side free");

	a_pass_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pass_detected |->
			out_data.duty_level == '0 && out_data.mode == MODE_W'(PH_IDLE))
		else $error("pass beat without zero duty and idle mode");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("beat activity straight after reset");

endmodule

bind proximity_pass_counter ppc_checker u_ppc_checker (.*);

/* tb/ppc_pass_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the proximity pass counter: watches the sample, result and register ports,
// predicts every result beat and compares it field by field. Depends on ppc_pkg.
module ppc_pass_checker
	import ppc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_beat_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_beat_t out_data,
	input  logic      cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int        results_owed,
	output int        mismatches
);

	logic [MARGIN_W-1:0] near_margin, deep_margin;
	logic [QUIET_W-1:0]  quiet_samples;
	logic [PCT_W-1:0]    high_share;
	logic [DUTY_W-1:0]   duty_near, duty_mid, duty_deep;

	phase_t               ph;
	logic [CAL_SUM_W-1:0] cal_acc;
	logic [CAL_CNT_W-1:0] cal_n;
	logic [DIST_W-1:0]    base_mm;
	logic [HITS_W-1:0]    near_cnt, mid_cnt;
	logic [QUIET_W-1:0]   quiet_cnt;
	logic [DUTY_W-1:0]    duty;

	out_beat_t predicted_reports [$];

	task automatic report(string msg);
		mismatches++;
		$display("%0t ns: %s", $time, msg);
	endtask

	function automatic out_beat_t advance_pass_logic(in_beat_t s);
		int        dist_v, near_lvl, deep_lvl;
		longint    nh, mh, total, prod, need;
		out_beat_t r;
		dist_v = int'(s.distance_mm);
		near_lvl = int'(base_mm) - int'(near_margin);
		deep_lvl = int'(base_mm) - int'(deep_margin);
		r.pass_detected = 1'b0;
		case (ph)
		PH_CAL: begin
			cal_acc = cal_acc + s.distance_mm;
			cal_n = cal_n + 1'b1;
			if (cal_n >= CAL_SAMPLES) begin
				base_mm = DIST_W'(cal_acc / CAL_SAMPLES);
				cal_acc = '0;
				cal_n = '0;
				ph = PH_IDLE;
			end
		end
		PH_IDLE: begin
			if (dist_v <= near_lvl) begin
				near_cnt = '0;
				mid_cnt = '0;
				quiet_cnt = quiet_samples;
				ph = PH_TRACK;
			end else if (s.recalibrate) begin
				cal_acc = '0;
				cal_n = '0;
				ph = PH_CAL;
			end
		end
		default: begin
			if (dist_v <= near_lvl) begin
				if (near_cnt != '1)
					near_cnt++;
				quiet_cnt = quiet_samples;
				duty = duty_near;
			end else if (dist_v <= int'(base_mm)) begin
				if (mid_cnt != '1)
					mid_cnt++;
				if (quiet_cnt != '0)
					quiet_cnt--;
				duty = duty_mid;
			end
			if (dist_v < deep_lvl)
				duty = duty_deep;
			if (quiet_cnt == '0) begin
				nh = near_cnt;
				mh = mid_cnt;
				total = nh + mh - longint'(quiet_samples);
				prod = total * longint'(high_share);
				// round towards minus infinity for a negative product
				if (prod >= 0)
					need = prod / 100;
				else
					need = -((-prod + 99) / 100);
				if (nh >= need) begin
					r.pass_detected = 1'b1;
					duty = '0;
				end
				near_cnt = '0;
				mid_cnt = '0;
				ph = PH_IDLE;
			end
		end
		endcase
		r.duty_level = duty;
		r.mode = ph;
		r.baseline_mm = base_mm;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_beat_t want;
		if (!arst_n) begin
			near_margin = NEAR_MARGIN_RST;
			deep_margin = DEEP_MARGIN_RST;
			quiet_samples = QUIET_SAMPLES_RST;
			high_share = HIGH_SHARE_RST;
			duty_near = DUTY_NEAR_RST;
			duty_mid = DUTY_MID_RST;
			duty_deep = DUTY_DEEP_RST;
			ph = PH_CAL;
			cal_acc = '0;
			cal_n = '0;
			base_mm = '0;
			near_cnt = '0;
			mid_cnt = '0;
			quiet_cnt = '0;
			duty = '0;
			predicted_reports.delete();
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_NEAR_MARGIN:   near_margin = cfg_data[MARGIN_W-1:0];
				REG_DEEP_MARGIN:   deep_margin = cfg_data[MARGIN_W-1:0];
				REG_QUIET_SAMPLES: quiet_samples = cfg_data[QUIET_W-1:0];
				REG_HIGH_SHARE:    high_share = cfg_data[PCT_W-1:0];
				REG_DUTY_NEAR:     duty_near = cfg_data;
				REG_DUTY_MID:      duty_mid = cfg_data;
				REG_DUTY_DEEP:     duty_deep = cfg_data;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_reports.size() == 0) begin
					report("result beat with nothing outstanding");
				end else begin
					want = predicted_reports.pop_front();
					if (out_data.pass_detected !== want.pass_detected)
						report($sformatf("pass_detected %b, expected %b",
							out_data.pass_detected, want.pass_detected));
					if (out_data.duty_level !== want.duty_level)
						report($sformatf("duty_level %0d, expected %0d",
							out_data.duty_level, want.duty_level));
					if (out_data.mode !== want.mode)
						report($sformatf("mode %0d, expected %0d",
							out_data.mode, want.mode));
					if (out_data.baseline_mm !== want.baseline_mm)
						report($sformatf("baseline_mm %0d, expected %0d",
							out_data.baseline_mm, want.baseline_mm));
				end
			end
			if (in_valid && !in_stall)
				predicted_reports.push_back(advance_pass_logic(in_data));
			results_owed <= predicted_reports.size();
		end
	end

endmodule

/* tb/proximity_pass_counter_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the proximity pass counter: clock, reset, sample and register stimulus,
// result back-pressure and the verdict. Depends on ppc_pkg, proximity_pass_counter and ppc_pass_checker.
module proximity_pass_counter_tb;
	import ppc_pkg::*;

	localparam int PHASE_BEATS = 110;
	localparam int HOLD_CYCLES = 64;
	localparam int DIST_MAX    = 16383;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_beat_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_beat_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int results_owed;
	int mismatches;

	int near_m = NEAR_MARGIN_RST;
	int deep_m = DEEP_MARGIN_RST;
	int quiet_n = QUIET_SAMPLES_RST;
	int base_est = 0;
	int gap_pct = 20;
	int stall_pct = 20;
	bit hold_req = 1'b0;
	int beats_sent = 0;

	proximity_pass_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ppc_pass_checker scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.results_owed (results_owed),
		.mismatches   (mismatches)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result back-pressure: random short bursts, or one long hold when asked
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_beat(int dist_v, bit recal);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{distance_mm: DIST_W'(dist_v), recalibrate: recal};
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	// a request bit only rides on samples that cannot be taken as a recalibration
	task automatic send_any(int dist_v);
		send_beat(dist_v, (dist_v <= base_est - near_m) ? 1'($urandom_range(0, 1)) : 1'b0);
	endtask

	function automatic int near_pick();
		int hi;
		hi = base_est - near_m;
		if (hi < 0)
			return 0;
		return $urandom_range(hi, (hi > 30) ? hi - 30 : 0);
	endfunction

	function automatic int above_pick();
		if (base_est >= DIST_MAX || $urandom_range(0, 9) == 0)
			return DIST_MAX;
		return $urandom_range(base_est + 1,
			(base_est + 300 > DIST_MAX) ? DIST_MAX : base_est + 300);
	endfunction

	function automatic int deep_pick();
		int hi;
		hi = base_est - deep_m - 1;
		if (hi < 0)
			return near_pick();
		if ($urandom_range(0, 9) == 0)
			return 0;
		return $urandom_range(hi, (hi > 40) ? hi - 40 : 0);
	endfunction

	function automatic int mid_pick();
		int lo;
		if (near_m == 0)
			return above_pick();
		lo = base_est - near_m + 1;
		return $urandom_range(base_est, (lo < 0) ? 0 : lo);
	endfunction

	function automatic int pick_target();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 40);
		if (r == 1)
			return $urandom_range(15900, 16000);
		return $urandom_range(300, 15800);
	endfunction

	function automatic int pick_pct();
		int r;
		r = $urandom_range(0, 2);
		return (r == 0) ? 0 : (r == 1) ? 15 : 35;
	endfunction

	task automatic write_reg(cfg_reg_t idx, int v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(v);
		@(posedge clk);
		case (idx)
		REG_NEAR_MARGIN:   near_m = v;
		REG_DEEP_MARGIN:   deep_m = v;
		REG_QUIET_SAMPLES: quiet_n = v;
		default: ;
		endcase
	endtask

	task automatic load_config(int nm, int dm, int qs, int pct, int dn, int dmid, int dd);
		write_reg(REG_NEAR_MARGIN, nm);
		write_reg(REG_DEEP_MARGIN, dm);
		write_reg(REG_QUIET_SAMPLES, qs);
		write_reg(REG_HIGH_SHARE, pct);
		write_reg(REG_DUTY_NEAR, dn);
		write_reg(REG_DUTY_MID, dmid);
		write_reg(REG_DUTY_DEEP, dd);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0 || hold_req)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// enough mid-band samples to run any quiet count down to zero; one above-baseline sample if the near margin is zero
	task automatic end_tracking();
		repeat ((near_m == 0) ? 1 : quiet_n + 1)
			send_beat(mid_pick(), 1'b0);
	endtask

	task automatic calibrate(bit ask, int target, int spread);
		int sum, v;
		sum = 0;
		if (ask)
			send_beat(DIST_MAX, 1'b1);
		repeat (CAL_SAMPLES) begin
			v = target + $urandom_range(0, spread);
			if (v > DIST_MAX)
				v = DIST_MAX;
			sum += v;
			send_beat(v, 1'($urandom_range(0, 1)));
		end
		base_est = sum / CAL_SAMPLES;
	endtask

	task automatic track_once();
		int share, r;
		share = $urandom_range(10, 80);
		send_any(near_pick());
		repeat ($urandom_range(1, 24)) begin
			r = $urandom_range(0, 99);
			if (r < share)
				send_any(near_pick());
			else if (r < share + 10)
				send_any(deep_pick());
			else if (r < 92)
				send_beat(mid_pick(), 1'b0);
			else
				send_beat(above_pick(), 1'b0);
		end
		if ($urandom_range(0, 3) != 0)
			end_tracking();
	endtask

	task automatic random_beats(int count);
		int stop_at, r;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				track_once();
			end else if (r < 84) begin
				repeat ($urandom_range(1, 5))
					send_beat(($urandom_range(0, 1) != 0) ? mid_pick() : above_pick(), 1'b0);
			end else if (r < 95) begin
				send_any($urandom_range(0, DIST_MAX));
			end else begin
				end_tracking();
				calibrate(1'b1, pick_target(), $urandom_range(0, 200));
			end
		end
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first baseline from extreme samples, request bits ignored while calibrating
		send_beat(DIST_MAX, 1'b0);
		send_beat(0, 1'b1);
		send_beat(DIST_MAX, 1'b0);
		send_beat(0, 1'b1);
		send_beat(1234, 1'b0);
		base_est = 6800;
		send_beat(6797, 1'b0);
		send_beat(6796, 1'b1);
		send_beat(6796, 1'b0);
		send_beat(6790, 1'b1);
		send_beat(6789, 1'b0);
		send_beat(DIST_MAX, 1'b1);
		send_beat(6800, 1'b0);
		repeat (4) send_beat(6797, 1'b0);
		// baseline below the margins: no sample can reach the near level
		send_beat(DIST_MAX, 1'b1);
		send_beat(0, 1'b0);
		send_beat(0, 1'b0);
		send_beat(1, 1'b0);
		send_beat(2, 1'b0);
		send_beat(3, 1'b0);
		base_est = 1;
		send_beat(0, 1'b0);

		for (int p = 1; p <= 10; p++) begin
			drain();
			case (p)
			1: load_config(0, 0, 0, 0, 0, 0, 0);
			2: load_config(255, 255, 15, 127, 1023, 1023, 1023);
			3: load_config(20, 60, 3, 100, 300, 700, 900);
			default: load_config($urandom_range(1, 255), $urandom_range(0, 255),
				($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 15),
				$urandom_range(0, 127), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
			endcase
			gap_pct = pick_pct();
			stall_pct = pick_pct();
			end_tracking();
			calibrate(1'b1, pick_target(), $urandom_range(0, 200));
			if (p == 5) begin
				gap_pct = 0;
				hold_req = 1'b1;
			end
			random_beats(PHASE_BEATS);
		end

		// no idling from here on; finish with one long track of alternating samples
		drain();
		gap_pct = 0;
		stall_pct = 0;
		load_config(12, 40, 2, 100, 511, 512, 1);
		end_tracking();
		calibrate(1'b1, 8000, 100);
		random_beats(100);
		end_tracking();
		send_beat(near_pick(), 1'b0);
		repeat (20) begin
			send_beat(near_pick(), 1'b0);
			send_beat(mid_pick(), 1'b0);
		end
		end_tracking();

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
